// ===== rtl/mab_pkg.sv =====
// ----------------------------------------------------------------------------
// mab_pkg: shared definitions for the max-alpha pixel blend
// Channel and register widths, the pixel record that travels down the
// pipeline, and the width rule for the clamped opacity.
// ----------------------------------------------------------------------------
package mab_pkg;

   // Width of one color channel.
   localparam int CH_W = 8;

   // Width of the opacity control register.
   localparam int CSR_W = 17;

   // Default number of fractional bits in the opacity.
   localparam int OPA_FRAC_BITS = 16;

   // One destination and one source pixel, plus the replace decision once known.
   typedef struct packed {
      logic [CH_W-1:0] dst_red;
      logic [CH_W-1:0] dst_green;
      logic [CH_W-1:0] dst_blue;
      logic [CH_W-1:0] dst_alpha;
      logic [CH_W-1:0] src_red;
      logic [CH_W-1:0] src_green;
      logic [CH_W-1:0] src_blue;
      logic [CH_W-1:0] src_alpha;
      logic            replaced;
   } pix_type;

   // Bits needed for the opacity after clamping to one.
   function automatic int opa_width(input int frac_bits);
      return (frac_bits + 1 < CSR_W) ? frac_bits + 1 : CSR_W;
   endfunction

endpackage

// ===== rtl/mab_scale.sv =====
// ----------------------------------------------------------------------------
// mab_scale: source alpha scaling
// Scales the source alpha by the opacity with half-up rounding, decides
// whether the source wins, and forms opacity times the alpha difference.
// ----------------------------------------------------------------------------
module mab_scale #(
   parameter int  OPA_FRAC_BITS = mab_pkg::OPA_FRAC_BITS,
   localparam int AW            = mab_pkg::opa_width(OPA_FRAC_BITS),
   localparam int PW            = AW + mab_pkg::CH_W
) (
   input  logic                           clock,
   input  logic [2:0]                     en,
   input  mab_pkg::pix_type               pix,
   input  logic [AW-1:0]                  opacity,
   output mab_pkg::pix_type               pix_out,
   output logic [PW-1:0]                  diff_prod,
   output logic [mab_pkg::CH_W-1:0]       scaled_alpha
);
   import mab_pkg::*;

   localparam int            SW   = PW + 1;
   localparam logic [SW-1:0] HALF = SW'(64'd1 << (OPA_FRAC_BITS - 1));

   pix_type         pix1_ff;
   logic [AW-1:0]   opa1_ff;
   logic [PW-1:0]   prod1_ff;

   logic [SW-1:0]   sum2;
   logic [SW-1:0]   shifted2;
   logic [CH_W-1:0] alpha2_in;
   pix_type         pix2_in;
   logic [CH_W-1:0] diff2_in;

   pix_type         pix2_ff;
   logic [AW-1:0]   opa2_ff;
   logic [CH_W-1:0] alpha2_ff;
   logic [CH_W-1:0] diff2_ff;

   pix_type         pix3_ff;
   logic [CH_W-1:0] alpha3_ff;
   logic [PW-1:0]   prod3_ff;

   // Stage 1: source alpha times opacity.
   always_ff @(posedge clock) begin
      if (en[0]) begin
         pix1_ff  <= pix;
         opa1_ff  <= opacity;
         prod1_ff <= PW'(pix.src_alpha) * PW'(opacity);
      end
   end

   // Stage 2 logic: round, saturate at full scale, compare against destination alpha.
   always_comb begin
      sum2      = SW'(prod1_ff) + HALF;
      shifted2  = SW'(sum2 >> OPA_FRAC_BITS);
      alpha2_in = (shifted2 > SW'(8'hFF)) ? 8'hFF : shifted2[CH_W-1:0];
      pix2_in   = pix1_ff;
      pix2_in.replaced = alpha2_in > pix1_ff.dst_alpha;
      diff2_in  = alpha2_in - pix1_ff.dst_alpha;
   end

   always_ff @(posedge clock) begin
      if (en[1]) begin
         pix2_ff   <= pix2_in;
         opa2_ff   <= opa1_ff;
         alpha2_ff <= alpha2_in;
         diff2_ff  <= diff2_in;
      end
   end

   // Stage 3: opacity times the alpha difference, the core of the divide numerator.
   always_ff @(posedge clock) begin
      if (en[2]) begin
         pix3_ff   <= pix2_ff;
         alpha3_ff <= alpha2_ff;
         prod3_ff  <= PW'(opa2_ff) * PW'(diff2_ff);
      end
   end

   assign pix_out      = pix3_ff;
   assign diff_prod    = prod3_ff;
   assign scaled_alpha = alpha3_ff;

endmodule

// ===== rtl/mab_div.sv =====
// ----------------------------------------------------------------------------
// mab_div: pipelined blend factor divider
// Computes the blend factor (2*A*(S-d) + S) / (2*S) with a restoring
// divider that retires one quotient bit per pipeline stage.
// ----------------------------------------------------------------------------
module mab_div #(
   parameter int  OPA_FRAC_BITS = mab_pkg::OPA_FRAC_BITS,
   localparam int AW            = mab_pkg::opa_width(OPA_FRAC_BITS),
   localparam int PW            = AW + mab_pkg::CH_W
) (
   input  logic                     clock,
   input  logic [AW:0]              en,
   input  mab_pkg::pix_type         pix_in,
   input  logic [PW-1:0]            diff_prod,
   input  logic [mab_pkg::CH_W-1:0] scaled_alpha,
   output mab_pkg::pix_type         pix_out,
   output logic [AW-1:0]            quotient
);
   import mab_pkg::*;

   // Numerator width; the divisor is twice the scaled alpha, so 9 bits.
   localparam int NW = PW + 1;
   localparam int DW = CH_W + 1;

   logic [NW-1:0] num0;

   logic [DW-1:0] rem_ff  [AW+1];
   logic [AW-1:0] low_ff  [AW+1];
   logic [DW-1:0] dvs_ff  [AW+1];
   pix_type       pix_ff  [AW+1];

   // Numerator assembly; the quotient never exceeds the opacity, so the upper
   // part of the numerator already sits below the divisor.
   assign num0 = NW'({diff_prod, 1'b0}) + NW'(scaled_alpha);

   always_ff @(posedge clock) begin
      if (en[0]) begin
         rem_ff[0] <= num0[AW+DW-1:AW];
         low_ff[0] <= num0[AW-1:0];
         dvs_ff[0] <= {scaled_alpha, 1'b0};
         pix_ff[0] <= pix_in;
      end
   end

   // One restoring step per stage: shift in the next numerator bit, subtract if it fits.
   for (genvar k = 1; k <= AW; k++) begin : g_step
      logic [DW:0]   cand;
      logic          fits;
      logic [DW-1:0] rem_in;
      logic [AW-1:0] low_in;

      always_comb begin
         cand   = {rem_ff[k-1], low_ff[k-1][AW-1]};
         fits   = cand >= {1'b0, dvs_ff[k-1]};
         rem_in = fits ? DW'(cand - {1'b0, dvs_ff[k-1]}) : cand[DW-1:0];
         low_in = {low_ff[k-1][AW-2:0], fits};
      end

      always_ff @(posedge clock) begin
         if (en[k]) begin
            rem_ff[k] <= rem_in;
            low_ff[k] <= low_in;
            dvs_ff[k] <= dvs_ff[k-1];
            pix_ff[k] <= pix_ff[k-1];
         end
      end
   end

   assign quotient = low_ff[AW];
   assign pix_out  = pix_ff[AW];

endmodule

// ===== rtl/mab_blend.sv =====
// ----------------------------------------------------------------------------
// mab_blend: per-channel blend and output register
// Multiplies each source channel by the blend factor, rounds half up and
// adds it to the destination channel with wraparound when the pixel is replaced; otherwise the destination passes.
// ----------------------------------------------------------------------------
module mab_blend #(
   parameter int  OPA_FRAC_BITS = mab_pkg::OPA_FRAC_BITS,
   localparam int AW            = mab_pkg::opa_width(OPA_FRAC_BITS)
) (
   input  logic                     clock,
   input  logic [1:0]               en,
   input  mab_pkg::pix_type         pix_in,
   input  logic [AW-1:0]            factor,
   output logic [mab_pkg::CH_W-1:0] out_red,
   output logic [mab_pkg::CH_W-1:0] out_green,
   output logic [mab_pkg::CH_W-1:0] out_blue,
   output logic [mab_pkg::CH_W-1:0] out_alpha,
   output logic                     replaced
);
   import mab_pkg::*;

   localparam int            PW   = AW + CH_W;
   localparam int            SW   = PW + 1;
   localparam logic [SW-1:0] HALF = SW'(64'd1 << (OPA_FRAC_BITS - 1));

   logic [CH_W-1:0] src_ch  [4];
   logic [CH_W-1:0] dst_ch  [4];
   logic [PW-1:0]   prod_ff [4];
   pix_type         pix1_ff;
   logic [CH_W-1:0] out_in  [4];
   logic [CH_W-1:0] out_ff  [4];
   logic            repl_ff;

   // Lane order is red, green, blue, alpha.
   assign src_ch[0] = pix_in.src_red;
   assign src_ch[1] = pix_in.src_green;
   assign src_ch[2] = pix_in.src_blue;
   assign src_ch[3] = pix_in.src_alpha;
   assign dst_ch[0] = pix1_ff.dst_red;
   assign dst_ch[1] = pix1_ff.dst_green;
   assign dst_ch[2] = pix1_ff.dst_blue;
   assign dst_ch[3] = pix1_ff.dst_alpha;

   // Stage 1: source channel times blend factor, one multiplier per lane.
   always_ff @(posedge clock) begin
      if (en[0]) begin
         pix1_ff <= pix_in;
         for (int i = 0; i < 4; i++) begin
            prod_ff[i] <= PW'(src_ch[i]) * PW'(factor);
         end
      end
   end

   // Stage 2 logic: round the share and add it; the destination passes when not replaced.
   always_comb begin
      logic [SW-1:0] sum;
      logic [SW-1:0] share;
      for (int i = 0; i < 4; i++) begin
         sum   = SW'(prod_ff[i]) + HALF;
         share = SW'(sum >> OPA_FRAC_BITS);
         out_in[i] = pix1_ff.replaced ? dst_ch[i] + share[CH_W-1:0] : dst_ch[i];
      end
   end

   always_ff @(posedge clock) begin
      if (en[1]) begin
         out_ff  <= out_in;
         repl_ff <= pix1_ff.replaced;
      end
   end

   assign out_red   = out_ff[0];
   assign out_green = out_ff[1];
   assign out_blue  = out_ff[2];
   assign out_alpha = out_ff[3];
   assign replaced  = repl_ff;

endmodule

// ===== rtl/max_alpha_pixel_blend.sv =====
// ----------------------------------------------------------------------------
// max_alpha_pixel_blend: max-alpha RGBA blend under a sample opacity
// Top level: opacity register, pipeline valid tracking and flow control.
// ----------------------------------------------------------------------------
// The block accepts one destination/source pixel pair per clock while
// req_stall is low and returns one blended pixel per request, in order.
// The opacity has OPA_FRAC_BITS fractional bits, 16 by default, and its
// width is capped at 17 bits. The blend factor divider retires one quotient
// bit per pipeline stage; three stages scale the source alpha ahead of it
// and two stages blend the channels after it. A stalled output holds only
// the stages that are full: bubbles inside the pipeline keep closing up,
// and req_stall rises only when every stage holds a request. The opacity
// is written through csr_wr_en and csr_wr_data, takes effect for requests
// accepted after the write, and values above one are used as one.
module max_alpha_pixel_blend #(
   parameter int OPA_FRAC_BITS = mab_pkg::OPA_FRAC_BITS
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_wr_en,
   input  logic [mab_pkg::CSR_W-1:0] csr_wr_data,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic [mab_pkg::CH_W-1:0]  req_dst_red,
   input  logic [mab_pkg::CH_W-1:0]  req_dst_green,
   input  logic [mab_pkg::CH_W-1:0]  req_dst_blue,
   input  logic [mab_pkg::CH_W-1:0]  req_dst_alpha,
   input  logic [mab_pkg::CH_W-1:0]  req_src_red,
   input  logic [mab_pkg::CH_W-1:0]  req_src_green,
   input  logic [mab_pkg::CH_W-1:0]  req_src_blue,
   input  logic [mab_pkg::CH_W-1:0]  req_src_alpha,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic [mab_pkg::CH_W-1:0]  rsp_out_red,
   output logic [mab_pkg::CH_W-1:0]  rsp_out_green,
   output logic [mab_pkg::CH_W-1:0]  rsp_out_blue,
   output logic [mab_pkg::CH_W-1:0]  rsp_out_alpha,
   output logic                      rsp_replaced
);
   import mab_pkg::*;

   localparam int AW       = opa_width(OPA_FRAC_BITS);
   localparam int PW       = AW + CH_W;
   localparam int SCALE_ST = 3;
   localparam int DIV_ST   = AW + 1;
   localparam int NS       = SCALE_ST + DIV_ST + 2;

   localparam logic [31:0]   OPA_ONE  = 32'(64'd1 << OPA_FRAC_BITS);
   localparam logic [31:0]   CSR_MAX  = 32'((64'd1 << CSR_W) - 64'd1);
   localparam logic [AW-1:0] OPA_RST  = AW'((OPA_ONE > CSR_MAX) ? CSR_MAX : OPA_ONE);

   logic [AW-1:0]   opacity_ff;
   logic [AW-1:0]   opacity_in;
   logic [NS-1:0]   vld_ff;
   logic [NS-1:0]   vld_in;
   logic [NS-1:0]   en;
   pix_type         req_pix;
   pix_type         scale_pix;
   pix_type         div_pix;
   logic [PW-1:0]   diff_prod;
   logic [CH_W-1:0] scaled_alpha;
   logic [AW-1:0]   factor;

   // Opacity register, clamped to one as it is written.
   assign opacity_in = ({{(32 - CSR_W){1'b0}}, csr_wr_data} > OPA_ONE) ?
                       AW'(OPA_ONE) : AW'(csr_wr_data);

   always_ff @(posedge clock) begin
      if (reset) begin
         opacity_ff <= OPA_RST;
      end else if (csr_wr_en) begin
         opacity_ff <= opacity_in;
      end
   end

   // A stage holds only if it and every stage after it are full and the output is stalled.
   always_comb begin
      for (int i = 0; i < NS; i++) begin
         en[i] = ~(rsp_stall & (&(vld_ff | ((NS'(1) << i) - NS'(1)))));
      end
   end

   assign req_stall = ~en[0];
   assign rsp_valid = vld_ff[NS-1];

   // Valid bits move with their stage's data.
   always_comb begin
      for (int i = 0; i < NS; i++) begin
         if (en[i]) begin
            vld_in[i] = (i == 0) ? req_valid : vld_ff[(i == 0) ? 0 : i - 1];
         end else begin
            vld_in[i] = vld_ff[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   // Request payload into the pixel record.
   always_comb begin
      req_pix           = '0;
      req_pix.dst_red   = req_dst_red;
      req_pix.dst_green = req_dst_green;
      req_pix.dst_blue  = req_dst_blue;
      req_pix.dst_alpha = req_dst_alpha;
      req_pix.src_red   = req_src_red;
      req_pix.src_green = req_src_green;
      req_pix.src_blue  = req_src_blue;
      req_pix.src_alpha = req_src_alpha;
   end

   mab_scale #(
      .OPA_FRAC_BITS (OPA_FRAC_BITS)
   ) u_scale (
      .clock        (clock),
      .en           (en[SCALE_ST-1:0]),
      .pix          (req_pix),
      .opacity      (opacity_ff),
      .pix_out      (scale_pix),
      .diff_prod    (diff_prod),
      .scaled_alpha (scaled_alpha)
   );

   mab_div #(
      .OPA_FRAC_BITS (OPA_FRAC_BITS)
   ) u_div (
      .clock        (clock),
      .en           (en[SCALE_ST+DIV_ST-1:SCALE_ST]),
      .pix_in       (scale_pix),
      .diff_prod    (diff_prod),
      .scaled_alpha (scaled_alpha),
      .pix_out      (div_pix),
      .quotient     (factor)
   );

   mab_blend #(
      .OPA_FRAC_BITS (OPA_FRAC_BITS)
   ) u_blend (
      .clock     (clock),
      .en        (en[NS-1:NS-2]),
      .pix_in    (div_pix),
      .factor    (factor),
      .out_red   (rsp_out_red),
      .out_green (rsp_out_green),
      .out_blue  (rsp_out_blue),
      .out_alpha (rsp_out_alpha),
      .replaced  (rsp_replaced)
   );

`ifndef SYNTH
   // The stored opacity never exceeds one.
   a_opacity_cap: assert property (@(posedge clock) disable iff (reset)
      {{(32 - AW){1'b0}}, opacity_ff} <= OPA_ONE)
      else $error("opacity register above one");

   // Requests are refused only when every pipeline stage is occupied.
   a_stall_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (&vld_ff))
      else $error("request stalled with a free pipeline stage");

   // Reset empties the pipeline.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> (vld_ff == '0))
      else $error("pipeline not empty after reset");
`endif

endmodule

// ===== test/max_alpha_pixel_blend_tb.sv =====
// ----------------------------------------------------------------------------
// max_alpha_pixel_blend_tb: self-checking bench for the max-alpha pixel blend
// Sends destination/source pixel pairs under a sequence of opacity settings
// and compares every blended pixel in order with the value computed here.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

// One blended pixel as the block should return it.
typedef struct packed {
   logic [mab_pkg::CH_W-1:0] out_red;
   logic [mab_pkg::CH_W-1:0] out_green;
   logic [mab_pkg::CH_W-1:0] out_blue;
   logic [mab_pkg::CH_W-1:0] out_alpha;
   logic                     replaced;
} blend_result_type;

// Computes the blend of each accepted request and holds the results in order.
class blend_ledger;
   localparam int FRAC = mab_pkg::OPA_FRAC_BITS;
   localparam longint unsigned OPA_ONE = 64'd1 << FRAC;
   localparam longint unsigned OPA_HALF = 64'd1 << (FRAC - 1);

   longint unsigned opacity;
   int unsigned mismatches;
   blend_result_type pending_blends[$];

   function new();
      opacity = OPA_ONE;
      mismatches = 0;
   endfunction

   // Max-alpha blend of one pixel pair under the current opacity.
   function blend_result_type blend_pixel(mab_pkg::pix_type p);
      longint unsigned a, s, m;
      longint unsigned dst[4], src[4];
      logic [mab_pkg::CH_W-1:0] sum[4];
      blend_result_type r;
      dst = '{p.dst_red, p.dst_green, p.dst_blue, p.dst_alpha};
      src = '{p.src_red, p.src_green, p.src_blue, p.src_alpha};
      // Opacity above one counts as one.
      a = (opacity > OPA_ONE) ? OPA_ONE : opacity;
      s = (src[3] * a + OPA_HALF) >> FRAC;
      if (s > 255) begin
         s = 255;
      end
      if (s > dst[3]) begin
         m = (2 * a * (s - dst[3]) + s) / (2 * s);
         // Each channel sum wraps to eight bits.
         for (int i = 0; i < 4; i++) begin
            sum[i] = mab_pkg::CH_W'(dst[i] + ((src[i] * m + OPA_HALF) >> FRAC));
         end
         r = '{sum[0], sum[1], sum[2], sum[3], 1'b1};
      end else begin
         r = '{p.dst_red, p.dst_green, p.dst_blue, p.dst_alpha, 1'b0};
      end
      return r;
   endfunction

   function void note_request(mab_pkg::pix_type p);
      pending_blends.push_back(blend_pixel(p));
   endfunction

   function void check_response(blend_result_type got);
      blend_result_type want;
      if (pending_blends.size() == 0) begin
         $error("unexpected response: red %0d green %0d blue %0d alpha %0d replaced %0d",
                got.out_red, got.out_green, got.out_blue, got.out_alpha, got.replaced);
         mismatches++;
         return;
      end
      want = pending_blends.pop_front();
      if (got.out_red !== want.out_red) begin
         $error("out_red: expected %0d, actual %0d", want.out_red, got.out_red);
         mismatches++;
      end
      if (got.out_green !== want.out_green) begin
         $error("out_green: expected %0d, actual %0d", want.out_green, got.out_green);
         mismatches++;
      end
      if (got.out_blue !== want.out_blue) begin
         $error("out_blue: expected %0d, actual %0d", want.out_blue, got.out_blue);
         mismatches++;
      end
      if (got.out_alpha !== want.out_alpha) begin
         $error("out_alpha: expected %0d, actual %0d", want.out_alpha, got.out_alpha);
         mismatches++;
      end
      if (got.replaced !== want.replaced) begin
         $error("replaced: expected %0d, actual %0d", want.replaced, got.replaced);
         mismatches++;
      end
   endfunction

   function int pending();
      return pending_blends.size();
   endfunction
endclass

module max_alpha_pixel_blend_tb;
   import mab_pkg::*;

   localparam int PIPE_DEPTH = OPA_FRAC_BITS + 7;
   localparam longint unsigned OPA_ONE = 64'd1 << OPA_FRAC_BITS;
   localparam int PHASE_REQUESTS = 85;

   logic             clock;
   logic             reset;
   logic             csr_wr_en;
   logic [CSR_W-1:0] csr_wr_data;
   logic             req_valid;
   logic             req_stall;
   pix_type          req;
   logic             rsp_valid;
   logic             rsp_stall;
   wire blend_result_type rsp;

   blend_ledger board;
   bit send_burst;
   bit recv_burst;

   max_alpha_pixel_blend dut (
      .clock        (clock),
      .reset        (reset),
      .csr_wr_en    (csr_wr_en),
      .csr_wr_data  (csr_wr_data),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_dst_red  (req.dst_red),
      .req_dst_green(req.dst_green),
      .req_dst_blue (req.dst_blue),
      .req_dst_alpha(req.dst_alpha),
      .req_src_red  (req.src_red),
      .req_src_green(req.src_green),
      .req_src_blue (req.src_blue),
      .req_src_alpha(req.src_alpha),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_out_red  (rsp.out_red),
      .rsp_out_green(rsp.out_green),
      .rsp_out_blue (rsp.out_blue),
      .rsp_out_alpha(rsp.out_alpha),
      .rsp_replaced (rsp.replaced)
   );

   // 20 ns clock.
   always begin
      clock = 1'b1;
      #10;
      clock = 1'b0;
      #10;
   end

   function automatic pix_type pixel(int dr, int dg, int db, int da,
                                     int sr, int sg, int sbl, int sa);
      pix_type p;
      p = '{dr[7:0], dg[7:0], db[7:0], da[7:0], sr[7:0], sg[7:0], sbl[7:0], sa[7:0], 1'b0};
      return p;
   endfunction

   // Sends one request; starts and ends at a falling edge.
   task automatic send_pixel(pix_type p);
      int gap;
      gap = send_burst ? 0 : $urandom_range(0, 9);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req <= p;
      req_valid <= 1'b1;
      do @(posedge clock); while (req_stall);
      board.note_request(p);
      @(negedge clock);
   endtask

   // Lets the pipeline empty, then writes a new opacity.
   task automatic write_opacity(logic [CSR_W-1:0] value);
      req_valid <= 1'b0;
      while (board.pending() != 0) @(negedge clock);
      repeat (PIPE_DEPTH) @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      board.opacity = value;
   endtask

   // One opacity setting followed by random pixel pairs.
   task automatic run_phase(logic [CSR_W-1:0] value);
      pix_type p;
      write_opacity(value);
      send_burst = ($urandom_range(0, 3) == 0);
      recv_burst = ($urandom_range(0, 3) == 0);
      for (int i = 0; i < PHASE_REQUESTS; i++) begin
         p = pixel($urandom, $urandom, $urandom, $urandom,
                   $urandom, $urandom, $urandom, $urandom);
         // Most pairs get a lower destination alpha so the blend path is taken.
         if ($urandom_range(0, 3) != 0) begin
            p.dst_alpha = CH_W'($urandom_range(0, p.src_alpha));
         end
         send_pixel(p);
      end
   endtask

   // Response side: checks each accepted result, then sometimes stalls for a while.
   initial begin
      int hold;
      rsp_stall = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && !rsp_stall) begin
            board.check_response(rsp);
            hold = recv_burst ? 0 : $urandom_range(0, 9);
            @(negedge clock);
            if (hold > 0) begin
               rsp_stall <= 1'b1;
               repeat (hold) @(negedge clock);
               rsp_stall <= 1'b0;
            end
         end
      end
   end

   // Main sequence: directed pairs at reset opacity, then opacity sweeps.
   initial begin
      pix_type directed[$];
      board = new();
      reset = 1'b1;
      csr_wr_en = 1'b0;
      csr_wr_data = '0;
      req_valid = 1'b0;
      req = '0;
      send_burst = 1'b0;
      recv_burst = 1'b0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      directed = '{
         pixel(0, 0, 0, 0, 0, 0, 0, 0),                  // all zero passes through
         pixel(255, 255, 255, 255, 255, 255, 255, 255),  // equal full alpha passes
         pixel(0, 0, 0, 0, 255, 255, 255, 255),          // full source onto empty
         pixel(255, 255, 255, 0, 255, 255, 255, 255),    // channel sums wrap
         pixel(200, 200, 200, 10, 200, 200, 200, 200),   // partial wrap
         pixel(9, 8, 7, 0, 40, 50, 60, 1),               // smallest scaled alpha
         pixel(30, 60, 90, 128, 10, 20, 30, 128),        // equal alpha passes
         pixel(30, 60, 90, 128, 10, 20, 30, 129),        // alpha just above
         pixel(1, 2, 3, 254, 250, 251, 252, 255),        // alpha one below full
         pixel(85, 170, 85, 0, 170, 85, 170, 255),       // alternating bits
         pixel(170, 85, 170, 85, 85, 170, 85, 170),
         pixel(0, 0, 0, 0, 0, 0, 0, 255),                // only alpha is added
         pixel(255, 0, 255, 100, 0, 255, 0, 99),         // source alpha below
         pixel(17, 34, 51, 0, 255, 0, 128, 128)
      };
      foreach (directed[i]) begin
         send_pixel(directed[i]);
      end

      // Zero, tiny, near one, one, above one, all ones and mid opacities.
      run_phase('0);
      run_phase(CSR_W'(1));
      run_phase(CSR_W'(OPA_ONE - 1));
      run_phase(CSR_W'(OPA_ONE));
      run_phase(CSR_W'(OPA_ONE + 1));
      run_phase('1);
      run_phase(CSR_W'(OPA_ONE / 2));
      run_phase(CSR_W'(OPA_ONE / 3));
      for (int i = 0; i < 3; i++) begin
         run_phase(CSR_W'($urandom_range(0, (1 << CSR_W) - 1)));
      end

      // Drain, then give stray responses time to show up.
      req_valid <= 1'b0;
      while (board.pending() != 0) @(negedge clock);
      repeat (PIPE_DEPTH + 5) @(negedge clock);
      if (board.mismatches == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

   // Run limit, far above the slowest legal run.
   initial begin
      #5_000_000;
      $display("tb: failure");
      $finish;
   end

endmodule
